### rtl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared constants and controller/datapath handshake types for the
// trial division prime test.
// ----------------------------------------------------------------------------
package tdpt_pkg;

	localparam int DEFAULT_WIDTH  = 16;
	localparam int SMALLEST_PRIME = 2;
	localparam int FIRST_DIVISOR  = 2;

	typedef struct packed {
		logic in_ready;
		logic load;
		logic div_start;
		logic div_step;
		logic d_incr;
		logic res_write;
		logic res_value;
	} cmd_t;

	typedef struct packed {
		logic n_small;
		logic d_over;
		logic div_last;
		logic rem_zero;
		logic out_free;
	} status_t;

endpackage

### rtl/tdpt_num_if.sv
// ----------------------------------------------------------------------------
// tdpt_num_if
// Input channel: one number to test per transaction.
// ----------------------------------------------------------------------------
interface tdpt_num_if #(
	parameter int WIDTH = tdpt_pkg::DEFAULT_WIDTH
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink   (input valid, input number, output ready);
endinterface

### rtl/tdpt_res_if.sv
// ----------------------------------------------------------------------------
// tdpt_res_if
// Result channel: one prime flag per transaction.
// ----------------------------------------------------------------------------
interface tdpt_res_if;
	logic valid;
	logic ready;
	logic is_prime;

	modport source (output valid, output is_prime, input ready);
	modport sink   (input valid, input is_prime, output ready);
endinterface

### rtl/tdpt_datapath.sv
// ----------------------------------------------------------------------------
// tdpt_datapath
// Operand, divisor and restoring remainder registers plus the result
// register toward the output channel.
// ----------------------------------------------------------------------------
module tdpt_datapath #(
	parameter int WIDTH = tdpt_pkg::DEFAULT_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [WIDTH-1:0]    number,
	input  tdpt_pkg::cmd_t      cmd,
	output tdpt_pkg::status_t   status,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                is_prime
);

	localparam int CW = $clog2(WIDTH);

	logic [WIDTH-1:0] n_q;
	logic [WIDTH-1:0] d_q;
	logic [WIDTH-1:0] r_q;
	logic [WIDTH-1:0] sh_q;
	logic [CW-1:0]    cnt_q;
	logic             res_valid_q;
	logic             res_q;
	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             fits;

	assign trial = {r_q, sh_q[WIDTH-1]};
	assign diff  = trial - {1'b0, d_q};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= number;
			d_q <= WIDTH'(tdpt_pkg::FIRST_DIVISOR);
		end else if (cmd.d_incr) begin
			d_q <= d_q + WIDTH'(1);
		end
		if (cmd.div_start) begin
			sh_q  <= n_q;
			r_q   <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			sh_q  <= {sh_q[WIDTH-2:0], 1'b0};
			r_q   <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
			cnt_q <= cnt_q + CW'(1);
		end
		if (cmd.res_write) begin
			res_q <= cmd.res_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.res_write) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign status.n_small  = n_q < WIDTH'(tdpt_pkg::SMALLEST_PRIME);
	assign status.d_over   = d_q > (n_q >> 1);
	assign status.div_last = cnt_q == CW'(WIDTH - 1);
	assign status.rem_zero = r_q == '0;
	assign status.out_free = !res_valid_q || out_ready;

	assign out_valid = res_valid_q;
	assign is_prime  = res_q;

endmodule

### rtl/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// tdpt_ctrl
// Sequencer: loads a number, walks the trial divisors and runs one
// bit-serial remainder per divisor, then posts the verdict.
// ----------------------------------------------------------------------------
module tdpt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  tdpt_pkg::status_t status,
	output tdpt_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_TEST  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.n_small || status.d_over) begin
					if (status.out_free) begin
						cmd.res_write = 1'b1;
						cmd.res_value = !status.n_small;
						state_d       = ST_IDLE;
					end
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_TEST;
				end
			end
			ST_TEST: begin
				if (status.rem_zero) begin
					if (status.out_free) begin
						cmd.res_write = 1'b1;
						cmd.res_value = 1'b0;
						state_d       = ST_IDLE;
					end
				end else begin
					cmd.d_incr = 1'b1;
					state_d    = ST_CHECK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Reports whether an unsigned number is prime by trial division.
//
// in_ch carries one number per transaction, out_ch one is_prime flag per
// transaction, in the same order. 0 and 1 are not prime. Divisors run from
// 2 up to floor(n/2); the search stops at the first exact divisor.
// Each divisor takes one bound check, WIDTH steps of the bit-serial
// restoring remainder unit and one zero test. One number is in work at a
// time; in_ch.ready is high while the sequencer is idle, even while a
// finished flag waits in the output register. When out_ch stalls with a
// flag pending, the next verdict waits until that register frees. arst_n
// empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
	parameter int WIDTH = tdpt_pkg::DEFAULT_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	tdpt_num_if.sink  in_ch,
	tdpt_res_if.source out_ch
);

	tdpt_pkg::cmd_t    cmd;
	tdpt_pkg::status_t status;

	tdpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.status   (status),
		.cmd      (cmd)
	);

	tdpt_datapath #(
		.WIDTH (WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.number    (in_ch.number),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.is_prime  (out_ch.is_prime)
	);

	assign in_ch.ready = cmd.in_ready;

	a_div_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !status.d_over && !status.n_small)
		else $error("remainder started on a divisor beyond the bound");

	a_small_not_prime: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_write && status.n_small |-> !cmd.res_value)
		else $error("zero or one reported prime");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_write |-> status.out_free)
		else $error("pending result overwritten");

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> cmd.div_step && !cmd.in_ready)
		else $error("remainder unit not stepping after start");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the trial division prime test against its own trial division
// predictor. It sends edge values, a large prime and random small, product
// and multiple-of-small-factor numbers, with random gaps on both channels
// and one long stall of the result channel.
// ----------------------------------------------------------------------------
class prime_verdict_board;
	bit expected_flags[$];
	int unsigned failures;

	function new();
		failures = 0;
	endfunction

	function bit trial_prime(int unsigned n);
		int unsigned d;
		if (n < tdpt_pkg::SMALLEST_PRIME)
			return 1'b0;
		for (d = tdpt_pkg::FIRST_DIVISOR; d * d <= n; d++) begin
			if (n % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function void note_number(int unsigned n);
		expected_flags.push_back(trial_prime(n));
	endfunction

	function void check_flag(logic flag);
		bit want;
		if (expected_flags.size() == 0) begin
			$error("is_prime: unexpected transaction, expected none, actual %0b", flag);
			failures++;
			return;
		end
		want = expected_flags.pop_front();
		if (flag !== want) begin
			$error("is_prime mismatch: expected %0b, actual %0b", want, flag);
			failures++;
		end
	endfunction

	function int unsigned pending();
		return expected_flags.size();
	endfunction
endclass

module tb;
	localparam int WIDTH       = tdpt_pkg::DEFAULT_WIDTH;
	localparam int N_DIRECTED  = 22;
	localparam int N_RANDOM    = 80;
	localparam int STALL_LEN   = 20000;
	localparam int IDLE_PCT    = 31;
	localparam int QUIET_LIMIT = 2_000_000;

	logic clk;
	logic arst_n;
	bit   steady;
	bit   held;
	int unsigned quiet_cycles;
	int unsigned flags_seen;

	prime_verdict_board verdicts;

	tdpt_num_if #(.WIDTH(WIDTH)) num_ch();
	tdpt_res_if res_ch();

	trial_division_prime_test #(.WIDTH(WIDTH)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (num_ch),
		.out_ch (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_number(input logic [WIDTH-1:0] n);
		@(negedge clk);
		if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			num_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		num_ch.valid  <= 1'b1;
		num_ch.number <= n;
		do @(posedge clk); while (!num_ch.ready);
		verdicts.note_number(n);
	endtask

	// result channel: random back-pressure plus one long hold
	initial begin
		res_ch.ready = 1'b0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!held && flags_seen >= N_DIRECTED) begin
				held = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (STALL_LEN) @(negedge clk);
			end
			res_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			verdicts.check_flag(res_ch.is_prime);
			flags_seen++;
		end
	end

	always @(posedge clk) begin
		if ((num_ch.valid && num_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		logic [WIDTH-1:0] directed[N_DIRECTED];
		int unsigned sel;
		int unsigned a;
		int unsigned b;
		logic [WIDTH-1:0] n;

		directed = '{0, 1, 2, 3, 4, 5, 6, 7, 9, 25, 49, 257, 1021, 4093,
			16383, 32767, 32768, 65025, 65533, 65534, 65535, 65521};

		verdicts = new();
		flags_seen = 0;
		quiet_cycles = 0;
		steady = 1'b0;
		arst_n = 1'b0;
		num_ch.valid = 1'b0;
		num_ch.number = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_number(directed[i]);

		for (int i = 0; i < N_RANDOM; i++) begin
			steady = (i >= 30 && i < 55);
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				n = WIDTH'($urandom_range(0, 1023));
			end else if (sel < 70) begin
				a = $urandom_range(2, 255);
				b = $urandom_range(2, 255);
				n = WIDTH'(a * b);
			end else if (sel < 90) begin
				n = WIDTH'($urandom_range(0, 21845) * 3);
			end else begin
				n = WIDTH'($urandom & 32'h0000_FFFE);
			end
			send_number(n);
		end
		steady = 1'b0;

		@(negedge clk);
		num_ch.valid <= 1'b0;

		while (verdicts.pending() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		if (verdicts.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
